/* rtl/core/hfcp_pkg.sv */
package hfcp_pkg;

   // Default capacity of the frame store, in bytes.
   localparam int MAX_STORED_DEFAULT = 135;

   // Framing characters and byte classes.
   localparam logic [7:0] CHAR_HASH   = 8'h23;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] ABORT_LOW   = 8'd34;
   localparam logic [7:0] ABORT_HIGH  = 8'd126;
   localparam logic [7:0] STORE_LOW   = 8'd39;
   localparam logic [7:0] STORE_HIGH  = 8'd125;

   // Length limits for a valid frame.
   localparam logic [7:0] LEN_MIN = 8'd3;
   localparam logic [7:0] LEN_MAX = 8'd128;

   // Command lengths and the stored counts that go with them.
   localparam logic [7:0] OPEN_LEN    = 8'd5;
   localparam logic [7:0] CLOSE_LEN   = 8'd6;
   localparam logic [7:0] OPEN_COUNT  = 8'd9;
   localparam logic [7:0] CLOSE_COUNT = 8'd10;

   typedef enum logic [2:0] {
      STATUS_LEN_ERR = 3'd0,
      STATUS_SUM_ERR = 3'd1,
      STATUS_UNKNOWN = 3'd2,
      STATUS_OPEN    = 3'd3,
      STATUS_CLOSE   = 3'd4
   } status_type;

   // Snapshot of the open frame.
   typedef struct packed {
      logic [7:0] count;
      logic [7:0] len_hi;
      logic [7:0] len_lo;
      logic [7:0] sum;
      logic [7:0] last;
      logic [7:0] second_last;
      logic       open_mismatch;
      logic       close_mismatch;
   } frame_type;

   typedef struct packed {
      status_type status;
      logic [7:0] declared_length;
      logic [7:0] computed_checksum;
   } result_type;

   // Returns {invalid, value} for an uppercase hex digit.
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b0, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   // Characters of the "open;" command.
   function automatic logic [7:0] open_char(input logic [2:0] pos);
      logic [7:0] r;
      case (pos)
         3'd0: r = "o";
         3'd1: r = "p";
         3'd2: r = "e";
         3'd3: r = "n";
         3'd4: r = ";";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // Characters of the "close;" command.
   function automatic logic [7:0] close_char(input logic [2:0] pos);
      logic [7:0] r;
      case (pos)
         3'd0: r = "c";
         3'd1: r = "l";
         3'd2: r = "o";
         3'd3: r = "s";
         3'd4: r = "e";
         3'd5: r = ";";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

/* rtl/core/hfcp_frame.sv */
module hfcp_frame
   import hfcp_pkg::*;
#(
   parameter int MAX_STORED = MAX_STORED_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output logic       emit,
   output frame_type  frame
);

   logic      active_ff;
   logic      active_in;
   frame_type frame_ff;
   frame_type frame_in;
   logic      is_hash;
   logic      is_abort;
   logic      is_stored;
   logic [7:0] pos;
   logic [7:0] leaving;

   // Classify the byte and work out the next frame state.
   always_comb begin
      is_hash   = (rx_byte == CHAR_HASH);
      is_abort  = (rx_byte <= ABORT_LOW) || (rx_byte >= ABORT_HIGH);
      is_stored = (rx_byte >= STORE_LOW) && (rx_byte <= STORE_HIGH);
      emit      = (rx_byte == CHAR_DOLLAR) && active_ff;
      pos       = frame_ff.count - 8'd4;
      leaving   = frame_ff.second_last;
      frame_in  = frame_ff;
      active_in = active_ff;

      if (is_hash || is_abort || emit) begin
         frame_in = '0;
      end
      if (is_hash) begin
         active_in = 1'b1;
      end else if (is_abort || emit) begin
         active_in = 1'b0;
      end

      // Store the byte; payload bytes leave the two-byte delay line here.
      if (active_ff && is_stored) begin
         if (frame_ff.count == 8'd0) begin
            frame_in.len_hi = rx_byte;
         end else if (frame_ff.count == 8'd1) begin
            frame_in.len_lo = rx_byte;
         end else begin
            if (frame_ff.count >= 8'd4) begin
               frame_in.sum = frame_ff.sum + leaving;
               if (pos >= OPEN_LEN || leaving != open_char(pos[2:0])) begin
                  frame_in.open_mismatch = 1'b1;
               end
               if (pos >= CLOSE_LEN || leaving != close_char(pos[2:0])) begin
                  frame_in.close_mismatch = 1'b1;
               end
            end
            frame_in.second_last = frame_ff.last;
            frame_in.last        = rx_byte;
         end
         frame_in.count = frame_ff.count + 8'd1;
      end

      // A full store drops the frame.
      if (frame_in.count >= 8'(MAX_STORED)) begin
         frame_in.count = '0;
         active_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         frame_ff  <= '0;
      end else if (step) begin
         active_ff <= active_in;
         frame_ff  <= frame_in;
      end
   end

   assign frame = frame_ff;

endmodule

/* rtl/core/hfcp_check.sv */
module hfcp_check
   import hfcp_pkg::*;
(
   input  frame_type  frame,
   output result_type result
);

   logic [4:0] hi;
   logic [4:0] lo;
   logic [4:0] ch;
   logic [4:0] cl;
   logic [7:0] len;

   // Validate the closed frame and classify the command.
   always_comb begin
      hi  = hex_nibble(frame.len_hi);
      lo  = hex_nibble(frame.len_lo);
      ch  = hex_nibble(frame.second_last);
      cl  = hex_nibble(frame.last);
      len = {hi[3:0], lo[3:0]};
      result.status            = STATUS_LEN_ERR;
      result.declared_length   = '0;
      result.computed_checksum = '0;
      if (!hi[4] && !lo[4]) begin
         result.declared_length = len;
         if (len >= LEN_MIN && len <= LEN_MAX && (len + 8'd1) == frame.count) begin
            result.computed_checksum = frame.sum;
            if (ch[4] || cl[4] || {ch[3:0], cl[3:0]} != frame.sum) begin
               result.status = STATUS_SUM_ERR;
            end else if (!frame.open_mismatch && frame.count == OPEN_COUNT) begin
               result.status = STATUS_OPEN;
            end else if (!frame.close_mismatch && frame.count == CLOSE_COUNT) begin
               result.status = STATUS_CLOSE;
            end else begin
               result.status = STATUS_UNKNOWN;
            end
         end
      end
   end

endmodule

/* rtl/core/hex_framed_command_parser.sv */
// A request's result is loaded into the result register when the request leaves the input
// register (input register, then frame state and result register together).
// Throughput: one byte per cycle when not stalled; requests are taken while a result waits.
// A request that closes a frame stalls only while the result register is still held.
// Reset (synchronous, active high) closes any open frame and empties both registers.
module hex_framed_command_parser
   import hfcp_pkg::*;
#(
   parameter int MAX_STORED = MAX_STORED_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_declared_length,
   output logic [7:0] rsp_computed_checksum
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_ff;
   logic       emit;
   logic       advance;
   logic       out_free;
   logic       load_out;
   frame_type  frame;
   result_type result;

   hfcp_frame #(
      .MAX_STORED(MAX_STORED)
   ) u_frame (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .rx_byte(in_byte_ff),
      .emit   (emit),
      .frame  (frame)
   );

   hfcp_check u_check (
      .frame (frame),
      .result(result)
   );

   // A request moves on unless it closes a frame and the result slot is held.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!emit || out_free);
   assign load_out  = advance && emit;
   assign req_stall = in_valid_ff && !advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Result register.
   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_ff.status;
   assign rsp_declared_length   = rsp_ff.declared_length;
   assign rsp_computed_checksum = rsp_ff.computed_checksum;

`ifndef SYNTHESIS
   // A closing request never overwrites a result that is still held.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && emit && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("closing request not held while result is stalled");

   // A new result appears only after a request that closed a frame.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(load_out))
      else $error("result without a closing request");

   // The stored count stays below the capacity.
   assert property (@(posedge clock) disable iff (reset)
      frame.count < 8'(MAX_STORED))
      else $error("stored count reached capacity");

   // A reported command carries the frame's sum as its checksum and a nonzero declared length.
   assert property (@(posedge clock) disable iff (reset)
      load_out && (result.status == STATUS_OPEN || result.status == STATUS_CLOSE)
      |-> (result.computed_checksum == frame.sum && result.declared_length != 8'd0))
      else $error("command reported for an invalid frame");
`endif

endmodule
